>>> hw/rtl/tdmr_pkg.sv
`default_nettype none

package tdmr_pkg;

   // register indexes, decoded from paddr[2]
   localparam logic REG_BACKGROUND = 1'b0;
   localparam logic REG_TEXT       = 1'b1;

   localparam int unsigned FRAME_PIXELS = 64;
   localparam int unsigned PIX_W        = $clog2(FRAME_PIXELS);

   typedef struct packed {
      logic [3:0] tens;
      logic [3:0] ones;
   } digits_type;

   typedef struct packed {
      logic [7:0] background;
      logic [7:0] text;
   } colors_type;

   // one glyph column of the 3x5 font: bit r lights glyph row r
   function automatic logic [4:0] font_column(input logic [3:0] digit, input logic [1:0] gcol);
      logic [14:0] glyph;
      begin
         case (digit)
            4'd0:    glyph = {5'h1F, 5'h11, 5'h1F};
            4'd1:    glyph = {5'h10, 5'h1F, 5'h11};
            4'd2:    glyph = {5'h17, 5'h15, 5'h1D};
            4'd3:    glyph = {5'h1F, 5'h15, 5'h15};
            4'd4:    glyph = {5'h1F, 5'h04, 5'h07};
            4'd5:    glyph = {5'h1D, 5'h15, 5'h17};
            4'd6:    glyph = {5'h1D, 5'h15, 5'h1F};
            4'd7:    glyph = {5'h1F, 5'h01, 5'h01};
            4'd8:    glyph = {5'h1F, 5'h15, 5'h1F};
            4'd9:    glyph = {5'h1F, 5'h15, 5'h17};
            default: glyph = '0;
         endcase
         case (gcol)
            2'd0:    font_column = glyph[4:0];
            2'd1:    font_column = glyph[9:5];
            2'd2:    font_column = glyph[14:10];
            default: font_column = '0;
         endcase
      end
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tdmr_front.sv
`default_nettype none

module tdmr_front
   import tdmr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire logic [7:0] in_number,
   output logic            out_valid,
   input  wire logic       out_ready,
   output digits_type      out_digits
);

   logic        valid_ff, valid_in;
   digits_type  digits_ff, digits_in;
   logic        load;
   logic [15:0] prod;
   logic [4:0]  quot;
   logic [7:0]  quot_x10;
   logic [7:0]  rem;

   // n/10 as (n*205)>>11, exact for every 8-bit n
   always_comb begin
      prod     = 16'(in_number) * 16'd205;
      quot     = prod[15:11];
      quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
      rem      = in_number - quot_x10;
      digits_in.ones = rem[3:0];
      if (quot >= 5'd20) begin
         digits_in.tens = 4'(quot - 5'd20);
      end else if (quot >= 5'd10) begin
         digits_in.tens = 4'(quot - 5'd10);
      end else begin
         digits_in.tens = quot[3:0];
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         digits_ff <= digits_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_digits = digits_ff;

endmodule

`default_nettype wire

>>> hw/rtl/tdmr_queue.sv
`default_nettype none

module tdmr_queue
   import tdmr_pkg::*;
#(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire digits_type in_digits,
   output logic            out_valid,
   input  wire logic       out_ready,
   output digits_type      out_digits
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   digits_type       slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready   = count_ff != CNT_W'(DEPTH);
   assign out_valid  = count_ff != '0;
   assign push       = in_valid && in_ready;
   assign pop        = out_valid && out_ready;
   assign out_digits = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= in_digits;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill beyond depth");

   a_count_push: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue fill not bumped on push");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/tdmr_back.sv
`default_nettype none

module tdmr_back
   import tdmr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire colors_type colors,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire digits_type in_digits,
   output logic            out_valid,
   input  wire logic       out_ready,
   output logic [7:0]      out_pixel_color,
   output logic            out_frame_last
);

   logic             active_ff, active_in;
   logic [PIX_W-1:0] cnt_ff, cnt_in;
   digits_type       digits_ff, digits_in;
   logic             valid_ff, valid_in;
   logic [7:0]       color_ff;
   logic             last_ff;
   logic             adv, emit, last, pop;
   logic [2:0]       col, row, grow;
   logic             in_rows, in_glyph;
   logic [3:0]       digit;
   logic [4:0]       glyph, glyph_bits;
   logic             lit;
   logic [7:0]       color;

   assign adv  = !valid_ff || out_ready;
   assign emit = adv && active_ff;
   assign last = cnt_ff == '1;
   // next frame is taken while idle, or in the cycle the last pixel of this one enters the pixel register
   assign pop      = in_valid && (!active_ff || (emit && last));
   assign in_ready = !active_ff || (emit && last);

   always_comb begin
      col     = cnt_ff[5:3];
      row     = cnt_ff[2:0];
      grow    = row - 3'd1;
      in_rows = (row >= 3'd1) && (row <= 3'd5);
      if (col < 3'd3) begin
         digit    = digits_ff.tens;
         in_glyph = 1'b1;
      end else if ((col >= 3'd4) && (col <= 3'd6)) begin
         digit    = digits_ff.ones;
         in_glyph = 1'b1;
      end else begin
         digit    = digits_ff.ones;
         in_glyph = 1'b0;
      end
      // columns 4..6 land on glyph columns 0..2 through the low bits
      glyph      = font_column(digit, col[1:0]);
      glyph_bits = glyph >> grow;
      lit        = in_rows && in_glyph && glyph_bits[0];
      color      = lit ? colors.text : colors.background;
   end

   always_comb begin
      active_in = active_ff;
      cnt_in    = cnt_ff;
      digits_in = digits_ff;
      valid_in  = valid_ff;
      if (emit) begin
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            active_in = 1'b0;
         end
      end
      if (pop) begin
         active_in = 1'b1;
         digits_in = in_digits;
      end
      if (adv) begin
         valid_in = active_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff    <= '0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      digits_ff <= digits_in;
      if (emit) begin
         color_ff <= color;
         last_ff  <= last;
      end
   end

   assign out_valid       = valid_ff;
   assign out_pixel_color = color_ff;
   assign out_frame_last  = last_ff;

`ifndef NO_ASSERTIONS
   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> cnt_ff == '0)
      else $error("pixel count not at frame start while idle");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      emit |=> out_valid && (out_frame_last == $past(last)))
      else $error("frame end flag out of step with pixel count");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/two_digit_matrix_renderer_top.sv
`default_nettype none

// channel   direction  handshake              payload
// req       in         req_valid / req_ready  req_number[7:0]
// rsp       out        rsp_valid / rsp_ready  rsp_pixel_color[7:0], rsp_frame_last
// csr       in/out     psel, penable, pready  pwrite, paddr[2:0], pwdata, prdata
//
// each number gives 64 pixels, one per cycle while rsp_ready stays high;
// the pixel counter of the back end sets that rate.
// the first pixel is offered after the front reg, queue, frame load and pixel reg.
// synchronous active-high reset empties both stages and the queue, colors go to 0 and 255.
// a low rsp_ready stalls only the back end; the front keeps taking numbers until the queue fills.
module two_digit_matrix_renderer_top
   import tdmr_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_number,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_pixel_color,
   output logic             rsp_frame_last,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   colors_type colors_ff, colors_in;
   logic       csr_write;
   logic       front_valid, front_ready;
   digits_type front_digits;
   logic       queue_valid, queue_ready;
   digits_type queue_digits;
   logic [7:0] read_value;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      colors_in = colors_ff;
      unique case (paddr[2])
         REG_BACKGROUND: begin
            read_value = colors_ff.background;
            if (csr_write) begin
               colors_in.background = pwdata[7:0];
            end
         end
         REG_TEXT: begin
            read_value = colors_ff.text;
            if (csr_write) begin
               colors_in.text = pwdata[7:0];
            end
         end
         default: begin
            read_value = '0;
         end
      endcase
   end

   assign prdata = {24'd0, read_value};

   always_ff @(posedge clock) begin
      if (reset) begin
         colors_ff.background <= 8'd0;
         colors_ff.text       <= 8'd255;
      end else begin
         colors_ff <= colors_in;
      end
   end

   tdmr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_number  (req_number),
      .out_valid  (front_valid),
      .out_ready  (front_ready),
      .out_digits (front_digits)
   );

   tdmr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (front_valid),
      .in_ready   (front_ready),
      .in_digits  (front_digits),
      .out_valid  (queue_valid),
      .out_ready  (queue_ready),
      .out_digits (queue_digits)
   );

   tdmr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .colors          (colors_ff),
      .in_valid        (queue_valid),
      .in_ready        (queue_ready),
      .in_digits       (queue_digits),
      .out_valid       (rsp_valid),
      .out_ready       (rsp_ready),
      .out_pixel_color (rsp_pixel_color),
      .out_frame_last  (rsp_frame_last)
   );

endmodule

`default_nettype wire

>>> tb/two_digit_matrix_renderer_checker.sv
`default_nettype none

module two_digit_matrix_renderer_checker
   import tdmr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [7:0]  req_number,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [7:0]  rsp_pixel_color,
   input  wire logic        rsp_frame_last,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   input  wire logic [31:0] prdata,
   input  wire logic        pready,
   output int               mismatch_count,
   output int               pixels_due
);

   typedef struct packed {
      logic [7:0] color;
      logic       last;
   } pixel_type;

   pixel_type  due_pixels[$];
   colors_type colors;

   // glyph columns left to right, column 0 in the top five bits
   function automatic logic [14:0] digit_glyph(input logic [3:0] digit);
      case (digit)
         4'd0:    return {5'h1F, 5'h11, 5'h1F};
         4'd1:    return {5'h11, 5'h1F, 5'h10};
         4'd2:    return {5'h1D, 5'h15, 5'h17};
         4'd3:    return {5'h15, 5'h15, 5'h1F};
         4'd4:    return {5'h07, 5'h04, 5'h1F};
         4'd5:    return {5'h17, 5'h15, 5'h1D};
         4'd6:    return {5'h1F, 5'h15, 5'h1D};
         4'd7:    return {5'h01, 5'h01, 5'h1F};
         4'd8:    return {5'h1F, 5'h15, 5'h1F};
         4'd9:    return {5'h17, 5'h15, 5'h1F};
         default: return '0;
      endcase
   endfunction

   function automatic logic pixel_lit(input logic [3:0] tens, input logic [3:0] ones,
                                      input int col, input int row);
      logic [14:0] glyph;
      int          gcol;
      if (row < 1 || row > 5) return 1'b0;
      if (col < 3) begin
         glyph = digit_glyph(tens);
         gcol  = col;
      end else if (col >= 4 && col < 7) begin
         glyph = digit_glyph(ones);
         gcol  = col - 4;
      end else begin
         return 1'b0;
      end
      // glyph row is row - 1, counted up from the low bit of the column
      return glyph[9 - 5 * gcol + row];
   endfunction

   task automatic queue_frame(input logic [7:0] number);
      logic [3:0] tens;
      logic [3:0] ones;
      pixel_type  px;
      tens = 4'((number / 10) % 10);
      ones = 4'(number % 10);
      for (int col = 0; col < 8; col++) begin
         for (int row = 0; row < 8; row++) begin
            px.color = pixel_lit(tens, ones, col, row) ? colors.text : colors.background;
            px.last  = (col == 7 && row == 7);
            due_pixels.push_back(px);
         end
      end
   endtask

   always @(posedge clock) begin
      pixel_type  want;
      logic [7:0] reg_value;
      if (reset) begin
         colors.background = 8'h00;
         colors.text       = 8'hFF;
         due_pixels.delete();
      end else begin
         if (psel && penable && pready) begin
            if (pwrite) begin
               case (paddr[2])
                  REG_BACKGROUND: colors.background = pwdata[7:0];
                  REG_TEXT:       colors.text       = pwdata[7:0];
               endcase
            end else begin
               reg_value = (paddr[2] == REG_TEXT) ? colors.text : colors.background;
               if (prdata[7:0] !== reg_value) begin
                  $error("prdata: expected %0d, got %0d", reg_value, prdata[7:0]);
                  mismatch_count++;
               end
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (due_pixels.size() == 0) begin
               $error("rsp item with nothing due: pixel_color %0d frame_last %0d",
                      rsp_pixel_color, rsp_frame_last);
               mismatch_count++;
            end else begin
               want = due_pixels.pop_front();
               if (rsp_pixel_color !== want.color) begin
                  $error("pixel_color: expected %0d, got %0d", want.color, rsp_pixel_color);
                  mismatch_count++;
               end
               if (rsp_frame_last !== want.last) begin
                  $error("frame_last: expected %0d, got %0d", want.last, rsp_frame_last);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) queue_frame(req_number);
      end
      pixels_due = due_pixels.size();
   end

endmodule

`default_nettype wire

>>> tb/tb_two_digit_matrix_renderer_top.sv
`default_nettype none

module tb_two_digit_matrix_renderer_top;
   import tdmr_pkg::*;

   localparam logic [2:0] ADDR_BACKGROUND = {REG_BACKGROUND, 2'b00};
   localparam logic [2:0] ADDR_TEXT       = {REG_TEXT, 2'b00};
   localparam int         QUIET_LIMIT     = 3000;
   localparam int         HOLD_CYCLES     = 400;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_number;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_pixel_color;
   logic        rsp_frame_last;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_request   = 0;
   int quiet_cycles;
   int mismatch_count;
   int pixels_due;

   two_digit_matrix_renderer_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_number      (req_number),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_frame_last  (rsp_frame_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   two_digit_matrix_renderer_checker frame_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_number      (req_number),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_frame_last  (rsp_frame_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .mismatch_count  (mismatch_count),
      .pixels_due      (pixels_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: random stalls, or one long hold-off when asked
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_request = 0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
             || (psel && penable && pready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("tb_two_digit_matrix_renderer_top: done, errors");
      $finish;
   end

   task automatic csr_cycle(input logic write, input logic [2:0] addr, input logic [7:0] color);
      logic [31:0] word;
      word       = $urandom;
      word[7:0]  = color;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= addr;
      pwdata  <= word;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_colors(input logic [7:0] background, input logic [7:0] text);
      csr_cycle(1'b1, ADDR_BACKGROUND, background);
      csr_cycle(1'b1, ADDR_TEXT, text);
      csr_cycle(1'b0, ADDR_BACKGROUND, 8'h00);
      csr_cycle(1'b0, ADDR_TEXT, 8'h00);
   endtask

   task automatic send_number(input logic [7:0] number);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid  <= 1'b1;
      req_number <= number;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_frames();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pixels_due != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input int count,
                            input bit hold_off);
      logic [7:0] number;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      if (hold_off) begin
         @(posedge clock);
         hold_request = 1;
      end
      for (int i = 0; i < count; i++) begin
         // a quarter of the numbers are drawn from 0..99 so both digits vary freely
         if ($urandom_range(3) == 0)
            number = 8'($urandom_range(99));
         else
            number = 8'($urandom_range(255));
         send_number(number);
      end
      drain_frames();
   endtask

   initial begin
      logic [7:0] directed_numbers[17];
      directed_numbers = '{8'd0, 8'd11, 8'd22, 8'd33, 8'd44, 8'd55, 8'd66, 8'd77, 8'd88,
                           8'd99, 8'd100, 8'd109, 8'd190, 8'd255, 8'd128, 8'd5, 8'd50};
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_number = 8'h00;
      psel       = 1'b0;
      penable    = 1'b0;
      pwrite     = 1'b0;
      paddr      = '0;
      pwdata     = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset colours first, read back before any write
      csr_cycle(1'b0, ADDR_BACKGROUND, 8'h00);
      csr_cycle(1'b0, ADDR_TEXT, 8'h00);
      foreach (directed_numbers[i]) send_number(directed_numbers[i]);
      drain_frames();

      // inverted extremes, with the receiver held off so the input backs up
      set_colors(8'hFF, 8'h00);
      run_phase(0, 0, 25, 1'b1);

      set_colors(8'($urandom), 8'($urandom));
      run_phase(60, 0, 25, 1'b0);

      set_colors(8'h00, 8'h00);
      run_phase(0, 60, 25, 1'b0);

      set_colors(8'($urandom), 8'($urandom));
      run_phase(26, 26, 25, 1'b0);

      if (mismatch_count == 0)
         $display("tb_two_digit_matrix_renderer_top: done, clean");
      else
         $display("tb_two_digit_matrix_renderer_top: done, errors");
      $finish;
   end

endmodule

`default_nettype wire
